@@ sv/pgrr_pkg.sv @@
// ---------------------------------------------------------------------------
// pgrr_pkg - shared definitions for the proportional glyph row renderer
// Sizes, item and register codes, configuration and queue command records.
// ---------------------------------------------------------------------------
package pgrr_pkg;

    // Store sizes and mask geometry (BITMAP_BYTES is a power of two)
    localparam int BITMAP_BYTES   = 4096;
    localparam int OFFSET_ENTRIES = 257;
    localparam int MAX_HEIGHT     = 32;
    localparam int MASK_WIDTH     = 16;

    localparam int BA_W      = $clog2(BITMAP_BYTES);
    localparam int OT_AW     = $clog2(OFFSET_ENTRIES);
    localparam int USED_W    = $clog2(MASK_WIDTH + 1);
    localparam int ROWS_W    = $clog2(MAX_HEIGHT + 1);
    // bytes fetched per row: enough for MASK_WIDTH bits at any bit phase
    localparam int WIN_BYTES = (MASK_WIDTH + 14) / 8;
    localparam int WIN_BITS  = WIN_BYTES * 8;
    localparam int PH_W      = $clog2(WIN_BYTES + 1);
    localparam int MASK_EXT  = (MASK_WIDTH > 16) ? MASK_WIDTH : 16;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    // Item modes
    localparam logic [1:0] MODE_LOAD_BITMAP = 2'd0;
    localparam logic [1:0] MODE_LOAD_OFFSET = 2'd1;
    localparam logic [1:0] MODE_START       = 2'd2;
    localparam logic [1:0] MODE_DRAW        = 2'd3;

    // Character code limits and the substitute glyph
    localparam logic [7:0] CODE_LOW       = 8'd32;
    localparam logic [7:0] CODE_HIGH_EXCL = 8'd127;
    localparam logic [7:0] CODE_SUBST     = 8'h3F;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd7;

    typedef struct packed {
        logic [7:0]         first_code;
        logic [7:0]         last_code;
        logic [8:0]         row_stride;
        logic [5:0]         glyph_height;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } cfg_t;

    // One queued command: a bitmap byte write or a character to render
    typedef struct packed {
        logic              is_draw;
        logic [BA_W-1:0]   baddr;
        logic [7:0]        bdata;
        logic [15:0]       pen_x;
        logic [15:0]       pen_y;
        logic [31:0]       ink;
        logic [15:0]       start;
        logic [USED_W-1:0] used;
        logic              over;
    } cmd_t;

    // Rows per character, saturated at MAX_HEIGHT
    function automatic logic [ROWS_W-1:0] rows_of(input logic [5:0] height);
        if (int'(height) > MAX_HEIGHT)
            return ROWS_W'(MAX_HEIGHT);
        else
            return ROWS_W'(height);
    endfunction

endpackage

@@ sv/proportional_glyph_row_renderer.sv @@
// ---------------------------------------------------------------------------
// proportional_glyph_row_renderer - proportional bitmap font row renderer
// Renders characters of a proportional bitmap font as clipped row masks.
//
//   port group   direction  handshake             carries
//   item in      in         in_valid / in_stall   load, start and draw items
//   result out   out        out_valid / out_stall one mask per glyph row
//   register     in/out     APB psel/penable      eight font and clip regs
//
// Offset-load and start items finish in the front; bitmap-load items are queued.
// A draw item passes glyph lookup in the front (LOOK0, LOOK1, PUSH), then the back
// fetches (MASK_WIDTH+14)/8 bitmap bytes per row through the single read
// port of the bitmap store, one row after another.
// A 4-entry command queue lets lookup of the next item overlap rendering.
// Reset clears control, pen and registers; the stores need no clearing.
// A stalled result holds in the output register; items enter until the queue fills.
// ---------------------------------------------------------------------------
module proportional_glyph_row_renderer (
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [11:0]        load_address,
    input  logic [15:0]        load_value,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic [31:0]        ink_in,
    input  logic [7:0]         char_code,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] row_y,
    output logic signed [15:0] span_x,
    output logic [15:0]        row_mask,
    output logic [31:0]        ink_out,
    output logic               last_row,
    output logic               width_overflow,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import pgrr_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    cmd_t                 q_wdata;
    cmd_t                 q_rdata;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FIRST_CODE:   cfg_next.first_code   = pwdata[7:0];
                REG_LAST_CODE:    cfg_next.last_code    = pwdata[7:0];
                REG_ROW_STRIDE:   cfg_next.row_stride   = pwdata[8:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = pwdata[5:0];
                REG_CLIP_LEFT:    cfg_next.clip_left    = pwdata[15:0];
                REG_CLIP_TOP:     cfg_next.clip_top     = pwdata[15:0];
                REG_CLIP_RIGHT:   cfg_next.clip_right   = pwdata[15:0];
                REG_CLIP_BOTTOM:  cfg_next.clip_bottom  = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (cfg_idx)
            REG_FIRST_CODE:   prdata = 32'(cfg_reg.first_code);
            REG_LAST_CODE:    prdata = 32'(cfg_reg.last_code);
            REG_ROW_STRIDE:   prdata = 32'(cfg_reg.row_stride);
            REG_GLYPH_HEIGHT: prdata = 32'(cfg_reg.glyph_height);
            REG_CLIP_LEFT:    prdata = 32'({cfg_reg.clip_left});
            REG_CLIP_TOP:     prdata = 32'({cfg_reg.clip_top});
            REG_CLIP_RIGHT:   prdata = 32'({cfg_reg.clip_right});
            REG_CLIP_BOTTOM:  prdata = 32'({cfg_reg.clip_bottom});
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_code   <= 8'd32;
            cfg_reg.last_code    <= 8'd126;
            cfg_reg.row_stride   <= 9'd1;
            cfg_reg.glyph_height <= 6'd16;
            cfg_reg.clip_left    <= '0;
            cfg_reg.clip_top     <= '0;
            cfg_reg.clip_right   <= '0;
            cfg_reg.clip_bottom  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: intake, offset lookup, pen tracking
    pgrr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .load_address (load_address),
        .load_value   (load_value),
        .start_x      (start_x),
        .start_y      (start_y),
        .ink_in       (ink_in),
        .char_code    (char_code),
        .q_push       (q_push),
        .q_wdata      (q_wdata),
        .q_full       (q_full)
    );

    pgrr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: bitmap store and row rendering
    pgrr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_y          (row_y),
        .span_x         (span_x),
        .row_mask       (row_mask),
        .ink_out        (ink_out),
        .last_row       (last_row),
        .width_overflow (width_overflow)
    );

endmodule

@@ sv/pgrr_ram.sv @@
// ---------------------------------------------------------------------------
// pgrr_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pgrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/pgrr_front.sv @@
// ---------------------------------------------------------------------------
// pgrr_front - item intake and glyph lookup
// Accepts items, owns the offset table and the pen, and turns draw and
// bitmap-load items into queued commands.
// ---------------------------------------------------------------------------
module pgrr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgrr_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [11:0]           load_address,
    input  logic [15:0]           load_value,
    input  logic signed [15:0]    start_x,
    input  logic signed [15:0]    start_y,
    input  logic [31:0]           ink_in,
    input  logic [7:0]            char_code,
    output logic                  q_push,
    output pgrr_pkg::cmd_t        q_wdata,
    input  logic                  q_full
);

    import pgrr_pkg::*;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_LOOK0 = 2'd1;
    localparam logic [1:0] F_LOOK1 = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [7:0]       gidx_reg, gidx_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      pen_x_reg, pen_x_next;
    logic [15:0]      pen_y_reg, pen_y_next;
    logic [31:0]      ink_reg, ink_next;

    logic [7:0]       code_clean;
    logic [7:0]       code_map;
    logic             glyph_ok;
    logic [7:0]       glyph_idx;
    logic             pair_ok;
    logic [15:0]      glyph_end;
    logic [15:0]      glyph_width;
    logic [ROWS_W-1:0] rows;

    logic             ot_we;
    logic [OT_AW-1:0] ot_raddr;
    logic [15:0]      ot_rdata;

    assign in_stall = (state_reg != F_IDLE);
    assign rows     = rows_of(cfg.glyph_height);

    // Character code to glyph index
    always_comb
    begin
        code_clean = (char_code < CODE_LOW || char_code >= CODE_HIGH_EXCL)
                   ? CODE_SUBST : char_code;
        code_map   = (code_clean < cfg.first_code || code_clean > cfg.last_code)
                   ? CODE_SUBST : code_clean;
        glyph_ok   = (code_map >= cfg.first_code) && (code_map <= cfg.last_code);
        glyph_idx  = code_map - cfg.first_code;
        pair_ok    = glyph_ok && (int'(glyph_idx) + 1 < OFFSET_ENTRIES);
    end

    // Offset table: written by offset-load items, read twice per glyph
    assign ot_we    = in_valid && !in_stall && (mode == MODE_LOAD_OFFSET)
                   && (int'(load_address) < OFFSET_ENTRIES);
    assign ot_raddr = (state_reg == F_IDLE) ? OT_AW'(glyph_idx)
                                            : OT_AW'({1'b0, gidx_reg} + 9'd1);

    pgrr_ram #(
        .WIDTH (16),
        .DEPTH (OFFSET_ENTRIES)
    ) u_offset_ram (
        .clk   (clk),
        .we    (ot_we),
        .waddr (OT_AW'(load_address)),
        .wdata (load_value),
        .raddr (ot_raddr),
        .rdata (ot_rdata)
    );

    // Glyph width from the end offset
    always_comb
    begin
        glyph_end   = ot_rdata;
        glyph_width = (glyph_end > cmd_reg.start) ? glyph_end - cmd_reg.start : 16'd0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        gidx_next  = gidx_reg;
        width_next = width_reg;
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        ink_next   = ink_reg;
        q_push     = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_LOAD_BITMAP:
                        begin
                            cmd_next.is_draw = 1'b0;
                            cmd_next.baddr   = BA_W'(load_address);
                            cmd_next.bdata   = load_value[7:0];
                            if (int'(load_address) < BITMAP_BYTES)
                            begin
                                state_next = F_PUSH;
                            end
                        end
                        MODE_LOAD_OFFSET:
                        begin
                            state_next = F_IDLE;
                        end
                        MODE_START:
                        begin
                            pen_x_next = start_x;
                            pen_y_next = start_y;
                            ink_next   = ink_in;
                        end
                        MODE_DRAW:
                        begin
                            cmd_next.is_draw = 1'b1;
                            cmd_next.pen_x   = pen_x_reg;
                            cmd_next.pen_y   = pen_y_reg;
                            cmd_next.ink     = ink_reg;
                            gidx_next        = glyph_idx;
                            if (pair_ok)
                            begin
                                state_next = F_LOOK0;
                            end
                            else
                            begin
                                // missing glyph: empty span
                                cmd_next.start = 16'd0;
                                cmd_next.used  = '0;
                                cmd_next.over  = 1'b0;
                                width_next     = 16'd0;
                                state_next     = F_PUSH;
                            end
                        end
                        default:
                        begin
                            state_next = F_IDLE;
                        end
                    endcase
                end
            end
            F_LOOK0:
            begin
                cmd_next.start = ot_rdata;
                state_next     = F_LOOK1;
            end
            F_LOOK1:
            begin
                width_next = glyph_width;
                if (int'(glyph_width) > MASK_WIDTH)
                begin
                    cmd_next.used = USED_W'(MASK_WIDTH);
                    cmd_next.over = 1'b1;
                end
                else
                begin
                    cmd_next.used = USED_W'(glyph_width);
                    cmd_next.over = 1'b0;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (cmd_reg.is_draw && rows == '0)
                begin
                    // no rows to render, pen still advances
                    pen_x_next = pen_x_reg + width_reg;
                    state_next = F_IDLE;
                end
                else if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                    if (cmd_reg.is_draw)
                    begin
                        pen_x_next = pen_x_reg + width_reg;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_wdata = cmd_reg;

    // Control and pen state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            ink_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            ink_reg   <= ink_next;
        end
    end

    // Command payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        gidx_reg  <= gidx_next;
        width_reg <= width_next;
    end

endmodule

@@ sv/pgrr_queue.sv @@
// ---------------------------------------------------------------------------
// pgrr_queue - command queue between front and back
// Small circular buffer of commands with full and empty flags.
// ---------------------------------------------------------------------------
module pgrr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pgrr_pkg::cmd_t wdata,
    output logic           full,
    input  logic           pop,
    output pgrr_pkg::cmd_t rdata,
    output logic           empty
);

    import pgrr_pkg::*;

    cmd_t            ent_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QP_W + 1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = ent_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/pgrr_back.sv @@
// ---------------------------------------------------------------------------
// pgrr_back - row renderer
// Executes queued commands: writes bitmap bytes, fetches each glyph row
// from the bitmap store, builds the clipped row mask and holds results.
// ---------------------------------------------------------------------------
module pgrr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pgrr_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  pgrr_pkg::cmd_t     q_rdata,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] row_y,
    output logic signed [15:0] span_x,
    output logic [15:0]        row_mask,
    output logic [31:0]        ink_out,
    output logic               last_row,
    output logic               width_overflow
);

    import pgrr_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [MASK_WIDTH-1:0] lane_ok_reg, lane_ok_next;
    logic [ROWS_W-1:0]     row_reg, row_next;
    logic [BA_W-1:0]       base_reg, base_next;
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [WIN_BITS-1:0]   win_reg, win_next;

    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           row_y_reg, span_x_reg, row_mask_reg;
    logic [31:0]           ink_out_reg;
    logic                  last_row_reg, over_reg;

    logic                  bm_we;
    logic [BA_W-1:0]       bm_raddr;
    logic [7:0]            bm_rdata;

    logic [ROWS_W-1:0]     rows;
    logic                  row_is_last;
    logic                  out_free;
    logic                  out_load;
    logic [MASK_WIDTH-1:0] lane_ok;
    logic [WIN_BITS-1:0]   win_shifted;
    logic [MASK_WIDTH-1:0] pix;
    logic [MASK_WIDTH-1:0] mask;
    logic [MASK_EXT-1:0]   mask_ext;
    logic [16:0]           cur_y;
    logic                  row_ok;

    assign rows        = rows_of(cfg.glyph_height);
    assign row_is_last = (row_reg == ROWS_W'(rows - 1'b1));
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_load    = (state_reg == B_EMIT) && out_free;
    assign q_pop       = (state_reg == B_IDLE) && !q_empty;

    // Bitmap store: written by load commands, read one byte per cycle
    assign bm_we    = q_pop && !q_rdata.is_draw;
    assign bm_raddr = base_reg + BA_W'(cmd_reg.start >> 3) + BA_W'(phase_reg);

    pgrr_ram #(
        .WIDTH (8),
        .DEPTH (BITMAP_BYTES)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (q_rdata.baddr),
        .wdata (q_rdata.bdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // Column visibility and glyph width per lane, taken once per character
    always_comb
    begin
        logic [16:0] lane_x;
        lane_x = '0;
        for (int i = 0; i < MASK_WIDTH; i++)
        begin
            lane_x     = {q_rdata.pen_x[15], q_rdata.pen_x} + 17'(i);
            lane_ok[i] = ($signed(lane_x) >= $signed({cfg.clip_left[15], cfg.clip_left}))
                      && ($signed(lane_x) < $signed({cfg.clip_right[15], cfg.clip_right}))
                      && (i < int'(q_rdata.used));
        end
    end

    // Row mask from the fetched byte window
    always_comb
    begin
        win_shifted = win_reg << cmd_reg.start[2:0];
        for (int i = 0; i < MASK_WIDTH; i++)
        begin
            pix[i] = win_shifted[WIN_BITS-1-i];
        end
        cur_y    = {cmd_reg.pen_y[15], cmd_reg.pen_y} + 17'(row_reg);
        row_ok   = ($signed(cur_y) >= $signed({cfg.clip_top[15], cfg.clip_top}))
                && ($signed(cur_y) < $signed({cfg.clip_bottom[15], cfg.clip_bottom}));
        mask     = row_ok ? (pix & lane_ok_reg) : '0;
        mask_ext = MASK_EXT'(mask);
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        lane_ok_next = lane_ok_reg;
        row_next     = row_reg;
        base_next    = base_reg;
        phase_next   = phase_reg;
        win_next     = win_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop && q_rdata.is_draw)
                begin
                    cmd_next     = q_rdata;
                    lane_ok_next = lane_ok;
                    row_next     = '0;
                    base_next    = '0;
                    phase_next   = '0;
                    state_next   = B_READ;
                end
            end
            B_READ:
            begin
                if (phase_reg != '0)
                begin
                    win_next = {win_reg[WIN_BITS-9:0], bm_rdata};
                end
                if (phase_reg == PH_W'(WIN_BYTES))
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    if (row_is_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        base_next  = base_reg + BA_W'(cfg.row_stride);
                        phase_next = '0;
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        lane_ok_reg <= lane_ok_next;
        row_reg     <= row_next;
        base_reg    <= base_next;
        phase_reg   <= phase_next;
        win_reg     <= win_next;
        if (out_load)
        begin
            row_y_reg    <= cur_y[15:0];
            span_x_reg   <= cmd_reg.pen_x;
            row_mask_reg <= mask_ext[15:0];
            ink_out_reg  <= cmd_reg.ink;
            last_row_reg <= row_is_last;
            over_reg     <= cmd_reg.over;
        end
    end

    assign out_valid      = out_valid_reg;
    assign row_y          = row_y_reg;
    assign span_x         = span_x_reg;
    assign row_mask       = row_mask_reg;
    assign ink_out        = ink_out_reg;
    assign last_row       = last_row_reg;
    assign width_overflow = over_reg;

endmodule

@@ sv/pgrr_checker.sv @@
// ---------------------------------------------------------------------------
// pgrr_checker - port-level checks for the glyph row renderer
// Watches the item and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module pgrr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         mode,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] row_y,
    input logic signed [15:0] span_x,
    input logic [15:0]        row_mask,
    input logic [31:0]        ink_out,
    input logic               last_row,
    input logic               width_overflow
);

    import pgrr_pkg::*;

    // A held result keeps every field
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_y) && $stable(span_x)
            && $stable(row_mask) && $stable(ink_out) && $stable(last_row)
            && $stable(width_overflow))
        else $error("result changed while stalled");

    // Items that become queue commands keep the front busy in the cycle after
    a_queued_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_LOAD_BITMAP || mode == MODE_DRAW)
            |=> in_stall)
        else $error("front free right after a queued item");

    // Offset loads and start items finish in their own cycle
    a_local_item_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_LOAD_OFFSET || mode == MODE_START)
            |=> !in_stall)
        else $error("front stalled after a table or start item");

endmodule

bind proportional_glyph_row_renderer pgrr_checker u_pgrr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .row_y          (row_y),
    .span_x         (span_x),
    .row_mask       (row_mask),
    .ink_out        (ink_out),
    .last_row       (last_row),
    .width_overflow (width_overflow)
);

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb - proportional glyph row renderer testbench
// Loads a random font through the item channel, then sends start, draw and
// load items under six register settings and three idle patterns. A glyph
// row predictor expects every row mask, and each result is checked field by
// field in order of arrival.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgrr_pkg::*;

    localparam int NUM_SETTINGS   = 6;
    localparam int RANDOM_ITEMS   = 18;
    localparam int SETTLE_CYCLES  = 120;
    localparam int QUIET_LIMIT    = 5000;
    // strike bytes loaded up front at the bottom of the store
    localparam int STRIKE_BYTES   = 56;
    // offset entries loaded up front: every glyph that draws can reach
    localparam int GLYPHS_LOW_LAST   = 48;
    localparam int GLYPHS_HIGH_FIRST = 63;
    localparam int GLYPHS_HIGH_LAST  = 73;
    // glyph '~' sits on the last two strike bytes and wraps to byte zero
    localparam logic [15:0] WRAP_START = 16'd32752;

    // One input item and one row result
    typedef struct {
        logic [1:0]         mode;
        logic [11:0]        load_address;
        logic [15:0]        load_value;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [31:0]        ink;
        logic [7:0]         code;
    } item_t;

    typedef struct {
        logic signed [15:0] row_y;
        logic signed [15:0] span_x;
        logic [15:0]        row_mask;
        logic [31:0]        ink_out;
        logic               last_row;
        logic               width_overflow;
    } row_t;

    // Glyph row predictor and the queue of rows still owed by the block
    class glyph_row_board;
        logic [7:0]         font_bytes [BITMAP_BYTES];
        logic [15:0]        glyph_start [OFFSET_ENTRIES];
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic [31:0]        ink;
        cfg_t               cfg;
        row_t               rows_due [$];
        int                 rows_checked;
        int                 mismatches;

        function new();
            pen_x = '0;
            pen_y = '0;
            ink   = '0;
            cfg   = '{8'd32, 8'd126, 9'd1, 6'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
            rows_checked = 0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_FIRST_CODE:   cfg.first_code   = value[7:0];
                REG_LAST_CODE:    cfg.last_code    = value[7:0];
                REG_ROW_STRIDE:   cfg.row_stride   = value[8:0];
                REG_GLYPH_HEIGHT: cfg.glyph_height = value[5:0];
                REG_CLIP_LEFT:    cfg.clip_left    = value[15:0];
                REG_CLIP_TOP:     cfg.clip_top     = value[15:0];
                REG_CLIP_RIGHT:   cfg.clip_right   = value[15:0];
                REG_CLIP_BOTTOM:  cfg.clip_bottom  = value[15:0];
                default: ;
            endcase
        endfunction

        // Update font and pen state; a draw item queues one row per glyph row
        function void note_item(item_t it);
            int                    code, lo, hi, rows, used, y, x;
            int unsigned           start, stop, width, pos, addr;
            logic                  wide;
            logic [MASK_WIDTH-1:0] paint;
            row_t                  row;
            case (it.mode)
                MODE_LOAD_BITMAP:
                    if (it.load_address < BITMAP_BYTES)
                        font_bytes[it.load_address] = it.load_value[7:0];
                MODE_LOAD_OFFSET:
                    if (it.load_address < OFFSET_ENTRIES)
                        glyph_start[it.load_address] = it.load_value;
                MODE_START:
                begin
                    pen_x = it.start_x;
                    pen_y = it.start_y;
                    ink   = it.ink;
                end
                default:
                begin
                    // non-printable or out-of-font codes fall back to '?'
                    code = it.code;
                    lo   = cfg.first_code;
                    hi   = cfg.last_code;
                    if (code < int'(CODE_LOW) || code >= int'(CODE_HIGH_EXCL))
                        code = int'(CODE_SUBST);
                    if (code < lo || code > hi)
                        code = int'(CODE_SUBST);
                    start = 0;
                    stop  = 0;
                    if (code >= lo && code <= hi && code - lo + 1 < OFFSET_ENTRIES)
                    begin
                        start = glyph_start[code - lo];
                        stop  = glyph_start[code - lo + 1];
                    end
                    width = (stop > start) ? stop - start : 0;
                    wide  = width > MASK_WIDTH;
                    used  = wide ? MASK_WIDTH : width;
                    rows  = (cfg.glyph_height > MAX_HEIGHT) ? MAX_HEIGHT
                                                            : cfg.glyph_height;
                    for (int r = 0; r < rows; r++)
                    begin
                        y     = int'(pen_y) + r;
                        paint = '0;
                        if (y >= int'($signed(cfg.clip_top)) &&
                            y < int'($signed(cfg.clip_bottom)))
                        begin
                            for (int i = 0; i < used; i++)
                            begin
                                x = int'(pen_x) + i;
                                if (x >= int'($signed(cfg.clip_left)) &&
                                    x < int'($signed(cfg.clip_right)))
                                begin
                                    pos  = start + i;
                                    addr = (r * cfg.row_stride + pos / 8) % BITMAP_BYTES;
                                    paint[i] = font_bytes[addr][7 - pos % 8];
                                end
                            end
                        end
                        row.row_y          = y[15:0];
                        row.span_x         = pen_x;
                        row.row_mask       = 16'(paint);
                        row.ink_out        = ink;
                        row.last_row       = (r + 1 == rows);
                        row.width_overflow = wide;
                        rows_due.push_back(row);
                    end
                    // pen advances by the full width, wrapping at 16 bits
                    pen_x = pen_x + width[15:0];
                end
            endcase
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_row(row_t got);
            row_t want;
            if (rows_due.size() == 0)
            begin
                $error("row result with none expected: row_y %0d span_x %0d",
                       got.row_y, got.span_x);
                mismatches++;
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            compare("row_y", want.row_y, got.row_y);
            compare("span_x", want.span_x, got.span_x);
            compare("row_mask", want.row_mask, got.row_mask);
            compare("ink_out", want.ink_out, got.ink_out);
            compare("last_row", want.last_row, got.last_row);
            compare("width_overflow", want.width_overflow, got.width_overflow);
        endfunction
    endclass

    // Block ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = MODE_LOAD_BITMAP;
    logic [11:0]        load_address = '0;
    logic [15:0]        load_value = '0;
    logic signed [15:0] start_x = '0;
    logic signed [15:0] start_y = '0;
    logic [31:0]        ink_in = '0;
    logic [7:0]         char_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] row_y;
    logic signed [15:0] span_x;
    logic [15:0]        row_mask;
    logic [31:0]        ink_out;
    logic               last_row;
    logic               width_overflow;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    glyph_row_board board;
    int             send_idle = 0;
    int             recv_idle = 0;
    int             items_sent = 0;
    int             quiet_cycles = 0;

    proportional_glyph_row_renderer uut (.*);

    always #6 clk = ~clk;

    // Receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // Result monitor
    always @(posedge clk)
    begin
        row_t got;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            got.row_y          = row_y;
            got.span_x         = span_x;
            got.row_mask       = row_mask;
            got.ink_out        = ink_out;
            got.last_row       = last_row;
            got.width_overflow = width_overflow;
            board.check_row(got);
        end
    end

    // Watchdog: cycles with work pending but no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else if (in_valid || board.rows_due.size() != 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // All fields random; callers overwrite what the mode needs
    function automatic item_t make_item(logic [1:0] m);
        item_t it;
        it.mode         = m;
        it.load_address = $urandom_range(4095);
        it.load_value   = $urandom_range(65535);
        it.start_x      = $urandom_range(65535);
        it.start_y      = $urandom_range(65535);
        it.ink          = $urandom();
        it.code         = $urandom_range(255);
        return it;
    endfunction

    // Draw codes: space to slash, A to H, '?', or non-printable
    function automatic logic [7:0] pick_code();
        int k;
        k = $urandom_range(39);
        if (k < 16)
            return 8'(32 + k);
        else if (k < 24)
            return 8'(65 + k - 16);
        else if (k < 28)
            return CODE_SUBST;
        else if (k < 34)
            return 8'($urandom_range(31));
        else
            return 8'($urandom_range(255, 127));
    endfunction

    // Present one item after random idle cycles, hold until accepted
    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        mode         <= it.mode;
        load_address <= it.load_address;
        load_value   <= it.load_value;
        start_x      <= it.start_x;
        start_y      <= it.start_y;
        ink_in       <= it.ink;
        char_code    <= it.code;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic send_load(logic [1:0] m, logic [11:0] addr, logic [15:0] value);
        item_t it;
        it              = make_item(m);
        it.load_address = addr;
        it.load_value   = value;
        send_item(it);
    endtask

    task automatic send_start(logic signed [15:0] x, logic signed [15:0] y,
                              logic [31:0] color);
        item_t it;
        it         = make_item(MODE_START);
        it.start_x = x;
        it.start_y = y;
        it.ink     = color;
        send_item(it);
    endtask

    task automatic send_draw(logic [7:0] code);
        item_t it;
        it      = make_item(MODE_DRAW);
        it.code = code;
        send_item(it);
    endtask

    // Register write: setup cycle, then access until pready
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
    endtask

    // Stop sending, let every owed row arrive and the queue run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (board.rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_t        settings [NUM_SETTINGS];
        cfg_t        s;
        item_t       it;
        logic [7:0]  probe_codes [7];
        int          pick;

        board = new();
        // wide window, full font, odd stride; then partial window with every
        // code in range; letters only with no '?', zero stride and saturated
        // height; zero height; reversed code range and window; height 40
        settings = '{
            '{8'd32,  8'd126, 9'd3,   6'd14, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
            '{8'd0,   8'd255, 9'd2,   6'd24, -16'sd8,     -16'sd4,     16'sd40,    16'sd20},
            '{8'd65,  8'd90,  9'd0,   6'd63, 16'sd0,      16'sd0,      16'sd30,    16'sd10},
            '{8'd33,  8'd126, 9'd1,   6'd0,  -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
            '{8'd200, 8'd10,  9'd511, 6'd1,  16'sd20,     16'sd5,      -16'sd20,   -16'sd5},
            '{8'd32,  8'd126, 9'd1,   6'd40, -16'sd16,    -16'sd8,     16'sd24,    16'sd12}
        };
        probe_codes = '{8'd0, 8'd31, 8'd32, 8'd126, 8'd127, 8'd255, "A"};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            // receiver-heavy idling, then sender-heavy, then none
            if (p < 2)
            begin
                send_idle = 34;
                recv_idle = 84;
            end
            else if (p < 4)
            begin
                send_idle = 84;
                recv_idle = 34;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end

            s = settings[p];
            write_reg(REG_FIRST_CODE, 32'(s.first_code));
            write_reg(REG_LAST_CODE, 32'(s.last_code));
            write_reg(REG_ROW_STRIDE, 32'(s.row_stride));
            write_reg(REG_GLYPH_HEIGHT, 32'(s.glyph_height));
            write_reg(REG_CLIP_LEFT, 32'(s.clip_left));
            write_reg(REG_CLIP_TOP, 32'(s.clip_top));
            write_reg(REG_CLIP_RIGHT, 32'(s.clip_right));
            write_reg(REG_CLIP_BOTTOM, 32'(s.clip_bottom));

            if (p == 0)
            begin
                // small strike at the bottom of the store plus its last two
                // bytes; offsets stay small so every row fetch lands there
                for (int a = 0; a < STRIKE_BYTES; a++)
                    send_load(MODE_LOAD_BITMAP, 12'(a), 16'($urandom_range(65535)));
                send_load(MODE_LOAD_BITMAP, 12'(BITMAP_BYTES - 2), 16'($urandom_range(255)));
                send_load(MODE_LOAD_BITMAP, 12'(BITMAP_BYTES - 1), 16'($urandom_range(255)));
                // even glyphs mostly 0..24 wide, odd ones mostly reversed
                for (int a = 0; a < OFFSET_ENTRIES; a++)
                begin
                    if (a <= GLYPHS_LOW_LAST ||
                        (a >= GLYPHS_HIGH_FIRST && a <= GLYPHS_HIGH_LAST))
                        send_load(MODE_LOAD_OFFSET, 12'(a),
                                  (a % 2 == 0) ? 16'($urandom_range(6))
                                               : 16'($urandom_range(24, 6)));
                end
                send_load(MODE_LOAD_OFFSET, 12'd94, WRAP_START);
                send_load(MODE_LOAD_OFFSET, 12'd95, WRAP_START + 16'd16);

                // directed: pen at the most negative corner, boundary codes
                send_start(-16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
                foreach (probe_codes[k])
                    send_draw(probe_codes[k]);
                // offset loads past the table are ignored
                send_load(MODE_LOAD_OFFSET, 12'd300, 16'hFFFF);
                send_load(MODE_LOAD_OFFSET, 12'd4095, 16'h0000);
                // bitmap loads keep only the low byte
                send_load(MODE_LOAD_BITMAP, 12'd4095, 16'hFFA5);
                send_load(MODE_LOAD_BITMAP, 12'd0, 16'h00FF);
                // glyph wider than the mask
                send_load(MODE_LOAD_OFFSET, 12'd55, 16'd100);
                send_load(MODE_LOAD_OFFSET, 12'd56, 16'd130);
                send_draw("W");
                // reversed span draws nothing
                send_load(MODE_LOAD_OFFSET, 12'd33, 16'd500);
                send_load(MODE_LOAD_OFFSET, 12'd34, 16'd400);
                send_draw("A");
                // pen and row wrap at the positive corner
                send_start(16'sd32767, 16'sd32767, 32'h0000_0000);
                send_draw("W");
                send_start(16'sd0, 16'sd0, 32'h1234_5678);
                send_draw("?");
                send_draw(" ");
            end

            // random mix: draws, pen moves, bitmap and offset updates
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    it      = make_item(MODE_DRAW);
                    it.code = pick_code();
                end
                else if (pick < 65)
                begin
                    it = make_item(MODE_START);
                    if ($urandom_range(4) != 0)
                    begin
                        it.start_x = 16'($urandom_range(100) - 40);
                        it.start_y = 16'($urandom_range(50) - 20);
                    end
                end
                else if (pick < 80)
                    it = make_item(MODE_LOAD_BITMAP);
                else
                begin
                    it = make_item(MODE_LOAD_OFFSET);
                    // mostly a small offset anywhere in the table; else a stray address
                    if ($urandom_range(19) < 17)
                    begin
                        it.load_address = 12'($urandom_range(OFFSET_ENTRIES - 1));
                        it.load_value   = 16'($urandom_range(24));
                    end
                    else
                        it.load_address = 12'($urandom_range(4095, OFFSET_ENTRIES));
                end
                send_item(it);
            end
            settle();
        end

        if (board.rows_due.size() != 0)
        begin
            $error("%0d expected rows never arrived", board.rows_due.size());
            board.mismatches++;
        end
        $display("Covered %0d items over %0d register settings and three idle patterns;",
                 items_sent, NUM_SETTINGS);
        $display("%0d glyph rows checked, %0d mismatches.",
                 board.rows_checked, board.mismatches);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
